[rtl/core/assert_macros.svh]
// Assertion helpers; define ASSERT_OFF to drop all checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/jbt_pkg.sv]
package jbt_pkg;

    typedef enum logic [3:0] {
        KIND_UNDEF    = 4'd0,
        KIND_END      = 4'd1,
        KIND_CB_OPEN  = 4'd2,
        KIND_CB_CLOSE = 4'd3,
        KIND_SB_OPEN  = 4'd4,
        KIND_SB_CLOSE = 4'd5,
        KIND_COLON    = 4'd6,
        KIND_COMMA    = 4'd7,
        KIND_STRING   = 4'd8,
        KIND_INTEGER  = 4'd9,
        KIND_DECIMAL  = 4'd10,
        KIND_BOOLEAN  = 4'd11,
        KIND_NULL     = 4'd12
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_STRING  = 3'd1,
        MODE_ESCAPE  = 3'd2,
        MODE_NUMBER  = 3'd3,
        MODE_LITERAL = 3'd4
    } mode_t;

    typedef struct packed {
        logic       is_token;
        kind_t      kind;
        logic [7:0] text_byte;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } lex_out_t;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;

    localparam logic [39:0] LIT_TRUE  = 40'h0074727565;
    localparam logic [39:0] LIT_FALSE = 40'h66616C7365;
    localparam logic [39:0] LIT_NULL  = 40'h006E756C6C;

    function automatic res_t mk_tok(input kind_t k);
        res_t r;
        r.is_token  = 1'b1;
        r.kind      = k;
        r.text_byte = 8'h00;
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic res_t mk_txt(input logic [7:0] b);
        res_t r;
        r.is_token  = 1'b0;
        r.kind      = KIND_UNDEF;
        r.text_byte = b;
        r.last      = 1'b0;
        return r;
    endfunction

endpackage

[rtl/core/jbt_lex.sv]
module jbt_lex
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  logic [7:0]         in_byte,
    input  logic               in_end,
    output jbt_pkg::lex_out_t  lex_out
);
    import jbt_pkg::*;

    typedef struct packed {
        logic       vld;
        res_t       res;
        mode_t      mode;
        logic       lit_load;
        logic [2:0] lit_left;
    } idle_t;

    mode_t       mode_reg, mode_next;
    logic [1:0]  dot_count_reg, dot_count_next;
    logic        last_dot_reg, last_dot_next;
    logic [2:0]  lit_left_reg, lit_left_next;
    logic [39:0] lit_buf_reg, lit_buf_next;

    idle_t       idl;
    logic [39:0] buf_shift;
    logic [2:0]  left_dec;
    kind_t       lit_kind;
    kind_t       num_kind;
    lex_out_t    o;

    function automatic idle_t idle_step(input logic [7:0] b);
        idle_t s;
        s.vld      = 1'b1;
        s.res      = mk_tok(KIND_UNDEF);
        s.mode     = MODE_IDLE;
        s.lit_load = 1'b0;
        s.lit_left = 3'd0;
        if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
        begin
            s.vld = 1'b0;
        end
        else
        begin
            unique case (b)
                CH_NUL:    s.res = mk_tok(KIND_END);
                CH_LBRACE: s.res = mk_tok(KIND_CB_OPEN);
                CH_RBRACE: s.res = mk_tok(KIND_CB_CLOSE);
                CH_LBRACK: s.res = mk_tok(KIND_SB_OPEN);
                CH_RBRACK: s.res = mk_tok(KIND_SB_CLOSE);
                CH_COLON:  s.res = mk_tok(KIND_COLON);
                CH_COMMA:  s.res = mk_tok(KIND_COMMA);
                CH_QUOTE:
                begin
                    s.vld  = 1'b0;
                    s.mode = MODE_STRING;
                end
                default:
                begin
                    if ((b >= CH_0 && b <= CH_9) || b == CH_MINUS)
                    begin
                        s.res  = mk_txt(b);
                        s.mode = MODE_NUMBER;
                    end
                    else if (b == CH_LC_N || b == CH_LC_T || b == CH_LC_F)
                    begin
                        s.res      = mk_txt(b);
                        s.mode     = MODE_LITERAL;
                        s.lit_load = 1'b1;
                        s.lit_left = (b == CH_LC_F) ? 3'd4 : 3'd3;
                    end
                end
            endcase
        end
        return s;
    endfunction

    function automatic logic [7:0] decode_escape(input logic [7:0] b);
        logic [7:0] d;
        unique case (b)
            CH_LC_B: d = 8'h08;
            CH_LC_F: d = 8'h0C;
            CH_LC_N: d = 8'h0A;
            CH_LC_R: d = 8'h0D;
            CH_LC_T: d = 8'h09;
            default: d = b;
        endcase
        return d;
    endfunction

    always_comb
    begin
        idl       = idle_step(in_byte);
        buf_shift = {lit_buf_reg[31:0], in_byte};
        left_dec  = (lit_left_reg == 3'd0) ? 3'd0 : lit_left_reg - 3'd1;
        if (buf_shift == LIT_TRUE || buf_shift == LIT_FALSE)
            lit_kind = KIND_BOOLEAN;
        else if (buf_shift == LIT_NULL)
            lit_kind = KIND_NULL;
        else
            lit_kind = KIND_UNDEF;
        if (last_dot_reg)
            num_kind = KIND_UNDEF;
        else if (dot_count_reg != 2'd0)
            num_kind = KIND_DECIMAL;
        else
            num_kind = KIND_INTEGER;
    end

    always_comb
    begin
        mode_next      = mode_reg;
        dot_count_next = dot_count_reg;
        last_dot_next  = last_dot_reg;
        lit_left_next  = lit_left_reg;
        lit_buf_next   = lit_buf_reg;
        o.n            = 2'd0;
        o.r0           = mk_tok(KIND_UNDEF);
        o.r1           = mk_tok(KIND_UNDEF);

        if (in_end)
        begin
            if (mode_reg == MODE_ESCAPE)
            begin
                o.r0 = mk_tok(KIND_STRING);
                o.r1 = mk_tok(KIND_END);
                o.n  = 2'd2;
            end
            else if (mode_reg != MODE_IDLE)
            begin
                o.r0 = mk_tok(KIND_UNDEF);
                o.r1 = mk_tok(KIND_END);
                o.n  = 2'd2;
            end
            else
            begin
                o.r0 = mk_tok(KIND_END);
                o.n  = 2'd1;
            end
            mode_next      = MODE_IDLE;
            dot_count_next = 2'd0;
            last_dot_next  = 1'b0;
            lit_left_next  = 3'd0;
            lit_buf_next   = 40'd0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_STRING:
                begin
                    if (in_byte == CH_QUOTE)
                    begin
                        o.r0      = mk_tok(KIND_STRING);
                        o.n       = 2'd1;
                        mode_next = MODE_IDLE;
                    end
                    else if (in_byte == CH_BSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else
                    begin
                        o.r0 = mk_txt(in_byte);
                        o.n  = 2'd1;
                    end
                end
                MODE_ESCAPE:
                begin
                    o.r0      = mk_txt(decode_escape(in_byte));
                    o.n       = 2'd1;
                    mode_next = MODE_STRING;
                end
                MODE_NUMBER:
                begin
                    if (dot_count_reg == 2'd2)
                    begin
                        // byte after a second dot is swallowed
                        o.r0           = mk_tok(KIND_UNDEF);
                        o.n            = 2'd1;
                        mode_next      = MODE_IDLE;
                        dot_count_next = 2'd0;
                        last_dot_next  = 1'b0;
                    end
                    else if (in_byte == CH_DOT)
                    begin
                        o.r0           = mk_txt(in_byte);
                        o.n            = 2'd1;
                        dot_count_next = dot_count_reg + 2'd1;
                        last_dot_next  = 1'b1;
                    end
                    else if (in_byte >= CH_0 && in_byte <= CH_9)
                    begin
                        o.r0          = mk_txt(in_byte);
                        o.n           = 2'd1;
                        last_dot_next = 1'b0;
                    end
                    else
                    begin
                        // terminator is lexed again as a token start
                        o.r0           = mk_tok(num_kind);
                        o.r1           = idl.res;
                        o.n            = idl.vld ? 2'd2 : 2'd1;
                        mode_next      = idl.mode;
                        dot_count_next = 2'd0;
                        last_dot_next  = 1'b0;
                        if (idl.lit_load)
                        begin
                            lit_left_next = idl.lit_left;
                            lit_buf_next  = {32'd0, in_byte};
                        end
                    end
                end
                MODE_LITERAL:
                begin
                    o.r0 = mk_txt(in_byte);
                    if (left_dec == 3'd0)
                    begin
                        o.r1          = mk_tok(lit_kind);
                        o.n           = 2'd2;
                        mode_next     = MODE_IDLE;
                        lit_left_next = 3'd0;
                        lit_buf_next  = 40'd0;
                    end
                    else
                    begin
                        o.n           = 2'd1;
                        lit_left_next = left_dec;
                        lit_buf_next  = buf_shift;
                    end
                end
                default:
                begin
                    o.r0           = idl.res;
                    o.n            = idl.vld ? 2'd1 : 2'd0;
                    mode_next      = idl.mode;
                    dot_count_next = 2'd0;
                    last_dot_next  = 1'b0;
                    if (idl.lit_load)
                    begin
                        lit_left_next = idl.lit_left;
                        lit_buf_next  = {32'd0, in_byte};
                    end
                end
            endcase
        end

        o.r0.last = (o.n == 2'd1);
        o.r1.last = 1'b1;
        lex_out   = o;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            dot_count_reg <= 2'd0;
            last_dot_reg  <= 1'b0;
            lit_left_reg  <= 3'd0;
            lit_buf_reg   <= 40'd0;
        end
        else if (step_en)
        begin
            mode_reg      <= mode_next;
            dot_count_reg <= dot_count_next;
            last_dot_reg  <= last_dot_next;
            lit_left_reg  <= lit_left_next;
            lit_buf_reg   <= lit_buf_next;
        end
    end

endmodule

[rtl/core/json_byte_tokenizer_top.sv]
// channel | dir | tdata           | tuser                         | tlast
// s_axis  | in  | [7:0] data_byte | [0] stream_end                | -
// m_axis  | out | [7:0] text_byte | [0] is_token [4:1] token_kind | last_result
//
// An accepted byte waits in the input register until the queue has room, is
// lexed combinationally and its 0..2 results enter a 4-entry result queue;
// results leave one per cycle while m_axis_tready is high, one result per transfer.
// rst_n (async) returns the lexer to idle and empties both stages.
// tready is high while the input register is empty or the queue holds two
// results or fewer.
module json_byte_tokenizer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] stream_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] text_byte
    output logic [7:0]  m_axis_tuser,   // [0] is_token, [4:1] token_kind
    output logic        m_axis_tlast
);
    import jbt_pkg::*;

    `include "assert_macros.svh"

    logic              in_vld_reg;
    logic [7:0]        in_byte_reg;
    logic              in_end_reg;
    logic              room;
    logic              fire;
    logic              pop;
    lex_out_t          lex_out;
    logic              end_tok_last;

    res_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [QCNT_W-1:0] push_n;
    res_t              head;

    assign room          = (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign fire          = in_vld_reg && room;
    assign s_axis_tready = !in_vld_reg || room;
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_axis_tvalid && s_axis_tready)
            in_vld_reg <= 1'b1;
        else if (fire)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tuser;
        end
    end

    jbt_lex u_lex
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (fire),
        .in_byte (in_byte_reg),
        .in_end  (in_end_reg),
        .lex_out (lex_out)
    );

    always_comb
    begin
        push_n      = fire ? QCNT_W'(lex_out.n) : '0;
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        cnt_next    = cnt_reg + push_n - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && lex_out.n != 2'd0)
            q_reg[wr_ptr_reg] <= lex_out.r0;
        if (fire && lex_out.n == 2'd2)
            q_reg[wr_ptr_reg + QPTR_W'(1)] <= lex_out.r1;
    end

    assign head          = q_reg[rd_ptr_reg];
    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tdata  = head.text_byte;
    assign m_axis_tuser  = {3'd0, head.kind, head.is_token};
    assign m_axis_tlast  = head.last;

    assign end_tok_last = (lex_out.n == 2'd2) ? (lex_out.r1.kind == KIND_END)
                                              : (lex_out.r0.kind == KIND_END);

    `ASSERT_IMPLY(a_q_bound, clk, rst_n, 1'b1, cnt_reg <= QCNT_W'(QDEPTH))
    `ASSERT_IMPLY(a_end_tok, clk, rst_n, fire && in_end_reg, end_tok_last)
    `ASSERT_NEXT(a_drain, clk, rst_n, pop && !fire, cnt_reg == $past(cnt_reg) - QCNT_W'(1))

endmodule

[bench/json_byte_tokenizer_top_test.sv]
`timescale 1ns / 100ps

module json_byte_tokenizer_top_test;

    import jbt_pkg::*;

    localparam int HOLD_CYCLES  = 150;
    localparam int TAIL_CYCLES  = 8;
    localparam int STALL_LIMIT  = 3000;
    localparam int DOC_ITEMS    = 600;
    localparam int TOTAL_ITEMS  = 880;

    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_LBRACE = "{";
    localparam logic [7:0] C_RBRACE = "}";
    localparam logic [7:0] C_LBRACK = "[";
    localparam logic [7:0] C_RBRACK = "]";
    localparam logic [7:0] C_COLON  = ":";
    localparam logic [7:0] C_COMMA  = ",";
    localparam logic [7:0] C_QUOTE  = "\"";
    localparam logic [7:0] C_BSLASH = "\\";
    localparam logic [7:0] C_MINUS  = "-";
    localparam logic [7:0] C_DOT    = ".";
    localparam logic [7:0] C_ZERO   = "0";
    localparam logic [7:0] C_NINE   = "9";

    localparam logic [39:0] WORD_TRUE  = 40'h0074727565;
    localparam logic [39:0] WORD_FALSE = 40'h66616C7365;
    localparam logic [39:0] WORD_NULL  = 40'h006E756C6C;

    typedef struct packed {
        logic       is_token;
        kind_t      kind;
        logic [7:0] text;
        logic       last;
    } lexeme_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [7:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // lexer state as seen by the predictor
    mode_t       lx_mode = MODE_IDLE;
    logic [1:0]  dot_cnt = 2'd0;
    logic        ends_in_dot = 1'b0;
    logic [2:0]  lit_left = 3'd0;
    logic [39:0] lit_text = 40'd0;

    lexeme_t     step_lexemes[$];
    lexeme_t     expected_lexemes[$];

    int unsigned accepted_items = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    bit          send_gapless = 1'b0;
    bit          recv_gapless = 1'b0;
    bit          stall_request = 1'b0;

    json_byte_tokenizer_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // ---------------- predictor ----------------

    function automatic void put(logic tok, kind_t k, logic [7:0] t);
        lexeme_t x;
        x.is_token = tok;
        x.kind     = k;
        x.text     = t;
        x.last     = 1'b0;
        if (step_lexemes.size() < 2)
            step_lexemes.insert(step_lexemes.size(), x);
    endfunction

    function automatic void reset_lexer();
        lx_mode     = MODE_IDLE;
        dot_cnt     = 2'd0;
        ends_in_dot = 1'b0;
        lit_left    = 3'd0;
        lit_text    = 40'd0;
    endfunction

    function automatic logic [7:0] unescape(logic [7:0] b);
        case (b)
            "b": return 8'h08;
            "f": return 8'h0C;
            "n": return 8'h0A;
            "r": return 8'h0D;
            "t": return 8'h09;
            default: return b;
        endcase
    endfunction

    function automatic void lex_token_start(logic [7:0] b);
        if (b == C_SPACE || (b >= 8'h09 && b <= 8'h0D))
            return;
        case (b)
            C_NUL:    put(1'b1, KIND_END, 8'h00);
            C_LBRACE: put(1'b1, KIND_CB_OPEN, 8'h00);
            C_RBRACE: put(1'b1, KIND_CB_CLOSE, 8'h00);
            C_LBRACK: put(1'b1, KIND_SB_OPEN, 8'h00);
            C_RBRACK: put(1'b1, KIND_SB_CLOSE, 8'h00);
            C_COLON:  put(1'b1, KIND_COLON, 8'h00);
            C_COMMA:  put(1'b1, KIND_COMMA, 8'h00);
            C_QUOTE:  lx_mode = MODE_STRING;
            default:
            begin
                if ((b >= C_ZERO && b <= C_NINE) || b == C_MINUS)
                begin
                    put(1'b0, KIND_UNDEF, b);
                    lx_mode     = MODE_NUMBER;
                    dot_cnt     = 2'd0;
                    ends_in_dot = 1'b0;
                end
                else if (b == "n" || b == "t" || b == "f")
                begin
                    put(1'b0, KIND_UNDEF, b);
                    lit_text = {32'd0, b};
                    lit_left = (b == "f") ? 3'd4 : 3'd3;
                    lx_mode  = MODE_LITERAL;
                end
                else
                    put(1'b1, KIND_UNDEF, 8'h00);
            end
        endcase
    endfunction

    function automatic void predict_lexemes(logic [7:0] b, logic eos);
        kind_t k;
        step_lexemes.delete();
        if (eos)
        begin
            if (lx_mode == MODE_ESCAPE)
                put(1'b1, KIND_STRING, 8'h00);
            else if (lx_mode != MODE_IDLE)
                put(1'b1, KIND_UNDEF, 8'h00);
            put(1'b1, KIND_END, 8'h00);
            reset_lexer();
        end
        else
        begin
            case (lx_mode)
                MODE_STRING:
                begin
                    if (b == C_QUOTE)
                    begin
                        put(1'b1, KIND_STRING, 8'h00);
                        lx_mode = MODE_IDLE;
                    end
                    else if (b == C_BSLASH)
                        lx_mode = MODE_ESCAPE;
                    else
                        put(1'b0, KIND_UNDEF, b);
                end
                MODE_ESCAPE:
                begin
                    put(1'b0, KIND_UNDEF, unescape(b));
                    lx_mode = MODE_STRING;
                end
                MODE_NUMBER:
                begin
                    if (dot_cnt >= 2'd2)
                    begin
                        // byte after the second dot is swallowed
                        put(1'b1, KIND_UNDEF, 8'h00);
                        reset_lexer();
                    end
                    else if (b == C_DOT)
                    begin
                        put(1'b0, KIND_UNDEF, b);
                        dot_cnt     = dot_cnt + 2'd1;
                        ends_in_dot = 1'b1;
                    end
                    else if (b >= C_ZERO && b <= C_NINE)
                    begin
                        put(1'b0, KIND_UNDEF, b);
                        ends_in_dot = 1'b0;
                    end
                    else
                    begin
                        k = ends_in_dot ? KIND_UNDEF
                          : ((dot_cnt != 2'd0) ? KIND_DECIMAL : KIND_INTEGER);
                        put(1'b1, k, 8'h00);
                        reset_lexer();
                        lex_token_start(b);
                    end
                end
                MODE_LITERAL:
                begin
                    put(1'b0, KIND_UNDEF, b);
                    lit_text = {lit_text[31:0], b};
                    if (lit_left > 3'd0)
                        lit_left = lit_left - 3'd1;
                    if (lit_left == 3'd0)
                    begin
                        k = KIND_UNDEF;
                        if (lit_text == WORD_TRUE || lit_text == WORD_FALSE)
                            k = KIND_BOOLEAN;
                        else if (lit_text == WORD_NULL)
                            k = KIND_NULL;
                        put(1'b1, k, 8'h00);
                        lit_text = 40'd0;
                        lx_mode  = MODE_IDLE;
                    end
                end
                default:
                begin
                    lx_mode = MODE_IDLE;
                    lex_token_start(b);
                end
            endcase
        end
        if (step_lexemes.size() > 0)
            step_lexemes[step_lexemes.size() - 1].last = 1'b1;
        foreach (step_lexemes[i])
            expected_lexemes.insert(expected_lexemes.size(), step_lexemes[i]);
    endfunction

    // ---------------- result checking ----------------

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        lexeme_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_lexemes.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, actual tdata=%h tuser=%h tlast=%b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatches++;
            end
            else
            begin
                want = expected_lexemes.pop_front();
                check_field("is_token", {7'd0, want.is_token}, {7'd0, m_axis_tuser[0]});
                check_field("token_kind", {4'd0, want.kind}, {4'd0, m_axis_tuser[4:1]});
                check_field("text_byte", want.text, m_axis_tdata);
                check_field("tuser pad", 8'd0, {5'd0, m_axis_tuser[7:5]});
                check_field("tlast", {7'd0, want.last}, {7'd0, m_axis_tlast});
            end
        end
    end

    // no transfer on either side for too long ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("json_byte_tokenizer_top_test NOT OK");
                $finish;
            end
        end
    end

    // ---------------- result receiver ----------------

    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            if (stall_request)
            begin
                stall_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = recv_gapless ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!m_axis_tvalid);
        end
    end

    // ---------------- byte sender ----------------

    task automatic send_item(input logic [7:0] b, input logic eos);
        int gap;
        gap = send_gapless ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= eos;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        predict_lexemes(b, eos);
        accepted_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_end_mark();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_lexemes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // ---------------- document pieces ----------------

    task automatic send_ws();
        string ws;
        ws = " \t\n\r\v\f";
        if ($urandom_range(0, 3) == 0)
            send_item(ws[$urandom_range(0, ws.len() - 1)], 1'b0);
    endtask

    task automatic send_string_token();
        string esc;
        logic [7:0] b;
        int len;
        esc = "bfnrtu/\"\\";
        len = $urandom_range(0, 6);
        send_ws();
        send_item(C_QUOTE, 1'b0);
        repeat (len)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                send_item(C_BSLASH, 1'b0);
                if ($urandom_range(0, 1) == 0)
                    send_item(esc[$urandom_range(0, esc.len() - 1)], 1'b0);
                else
                    send_item(8'($urandom_range(0, 255)), 1'b0);
            end
            else
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == C_QUOTE || b == C_BSLASH);
                send_item(b, 1'b0);
            end
        end
        send_item(C_QUOTE, 1'b0);
    endtask

    task automatic send_digits(input int lo, input int hi);
        repeat ($urandom_range(lo, hi))
            send_item(C_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    endtask

    task automatic send_number_token();
        int shape;
        send_ws();
        if ($urandom_range(0, 2) == 0)
            send_item(C_MINUS, 1'b0);
        send_digits(1, 4);
        shape = $urandom_range(0, 9);
        if (shape < 3)
        begin
            send_item(C_DOT, 1'b0);
            send_digits(1, 3);
        end
        else if (shape == 3)
        begin
            send_item(C_DOT, 1'b0);
            send_digits(0, 2);
            send_item(C_DOT, 1'b0);
        end
        else if (shape == 4)
            send_item(C_DOT, 1'b0);
    endtask

    task automatic send_literal_token();
        string starts;
        int pick;
        logic [7:0] first;
        starts = "tfn";
        send_ws();
        pick = $urandom_range(0, 9);
        if (pick < 3)
            send_text("true");
        else if (pick < 6)
            send_text("false");
        else if (pick < 9)
            send_text("null");
        else
        begin
            first = starts[$urandom_range(0, 2)];
            send_item(first, 1'b0);
            repeat ((first == "f") ? 4 : 3)
                send_item(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic send_value();
        int pick;
        int n;
        pick = $urandom_range(0, 5);
        if (pick < 2)
            send_string_token();
        else if (pick < 4)
            send_number_token();
        else if (pick == 4)
            send_literal_token();
        else
        begin
            send_item(C_LBRACK, 1'b0);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_number_token();
                else
                    send_literal_token();
                if (i != n - 1)
                    send_item(C_COMMA, 1'b0);
            end
            send_ws();
            send_item(C_RBRACK, 1'b0);
        end
    endtask

    task automatic send_document();
        int n;
        int finish_kind;
        send_ws();
        send_item(C_LBRACE, 1'b0);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++)
        begin
            send_string_token();
            send_ws();
            send_item(C_COLON, 1'b0);
            send_value();
            if (i != n - 1)
                send_item(C_COMMA, 1'b0);
        end
        send_ws();
        send_item(C_RBRACE, 1'b0);
        finish_kind = $urandom_range(0, 7);
        if (finish_kind == 5)
            send_item(C_NUL, 1'b0);
        else
        begin
            // finish kinds 6 and 7 end the stream inside an open token
            if (finish_kind == 6)
                send_text("\"ab");
            else if (finish_kind == 7)
                send_item(($urandom_range(0, 1) == 0) ? C_MINUS : 8'("n"), 1'b0);
            send_end_mark();
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_punctuation_and_unknown();
        send_text("{}[]:,");
        send_item(8'hFF, 1'b0);
        send_text(" \r");
        send_item(C_NUL, 1'b0);
    endtask

    task automatic test_strings_and_escapes();
        send_text("\"\\n\\z\"");
    endtask

    task automatic test_number_corners();
        // second dot, lone minus, trailing dot
        send_text("1.2.3-,9.]");
    endtask

    task automatic test_literal_and_stream_end();
        send_text("true");
        send_text("\"\\");
        send_end_mark();
    endtask

    task automatic test_random_documents();
        send_gapless = 1'b1;
        recv_gapless = 1'b1;
        repeat (3) send_document();
        send_gapless = 1'b0;
        recv_gapless = 1'b0;
        while (accepted_items < DOC_ITEMS)
            send_document();
    endtask

    task automatic test_output_stall();
        drain();
        stall_request = 1'b1;
        send_gapless  = 1'b1;
        send_item(C_QUOTE, 1'b0);
        repeat (38) send_item("a" + 8'($urandom_range(0, 25)), 1'b0);
        send_item(C_QUOTE, 1'b0);
        send_gapless = 1'b0;
        drain();
    endtask

    task automatic test_random_noise();
        string hot;
        int pick;
        hot = "{}[]:,\"\\-.0123456789tfnrue \t";
        while (accepted_items < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 24);
            if (pick == 0)
                send_end_mark();
            else if (pick <= 12)
                send_item(hot[$urandom_range(0, hot.len() - 1)], 1'b0);
            else
                send_item(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_punctuation_and_unknown();
        test_strings_and_escapes();
        test_number_corners();
        test_literal_and_stream_end();
        test_random_documents();
        test_output_stall();
        test_random_noise();
        drain();
        if (mismatches == 0 && expected_lexemes.size() == 0)
            $display("json_byte_tokenizer_top_test OK");
        else
            $display("json_byte_tokenizer_top_test NOT OK");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/jbt_pkg.sv
rtl/core/jbt_lex.sv
rtl/core/json_byte_tokenizer_top.sv
bench/json_byte_tokenizer_top_test.sv
